/* design/tobm_pkg.sv */
// Package: shared constants and types for the tick order book matcher.
`timescale 1ns / 1ps
`default_nettype none
package tobm_pkg;
  localparam int BOOK_DEPTH = 16;
  localparam int CNT_W = $clog2(BOOK_DEPTH + 1);

  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [1:0] SIDE_BUY  = 2'd0;
  localparam logic [1:0] SIDE_SELL = 2'd1;

  typedef struct packed {
    logic [31:0] price;
    logic [31:0] volume;
    logic [31:0] queue;
    logic [15:0] ident;
  } entry_t;

  // Per-slot control from the sequencer to every cell of one side.
  typedef struct packed {
    logic shift;   // rotate the ring by one slot
    logic load;    // write the append entry into the tail slot
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  side;
    logic [31:0] price;
    logic [31:0] volume;
    logic [31:0] queue_ahead;
    logic [15:0] order_id;
    logic [47:0] timestamp;
  } req_t;

  typedef struct packed {
    logic        has_fill;
    logic        fill_side;
    logic [31:0] fill_price;
    logic [31:0] fill_volume;
    logic [15:0] filled_id;
    logic [47:0] fill_time;
    logic        status;
    logic        last;
  } rsp_t;
endpackage
`default_nettype wire

/* design/tobm_if.sv */
// Interfaces: valid/ready channels for requests and results.
`timescale 1ns / 1ps
`default_nettype none
interface tobm_req_if import tobm_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tobm_rsp_if import tobm_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/tobm_cell.sv */
// Cell: one book slot that takes the entry of its neighbor when the ring turns.
`timescale 1ns / 1ps
`default_nettype none
module tobm_cell import tobm_pkg::*; (
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire entry_t    prev,     // entry of the neighbor
  input  wire entry_t    head_new, // updated head entry (last slot only)
  input  wire logic      use_head,
  input  wire entry_t    load_val,
  output entry_t         q
);
  entry_t val;
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val <= load_val;
    end else if (ctl.shift) begin
      val <= use_head ? head_new : prev;
    end
  end
  assign q = val;
endmodule
`default_nettype wire

/* design/tobm_side.sv */
// Side: a ring of cells; slot 0 is the head seen by the matcher.
`timescale 1ns / 1ps
`default_nettype none
module tobm_side import tobm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      shift,
  input  wire logic      load,
  input  wire logic [CNT_W-1:0] load_idx,
  input  wire entry_t    load_val,
  input  wire entry_t    head_new,  // processed head, re-enters at the tail
  output entry_t         head
);
  localparam int IW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  entry_t q [BOOK_DEPTH];
  for (genvar g = 0; g < BOOK_DEPTH; g++) begin : g_cell
    cell_ctl_t c;
    assign c.shift = shift;
    assign c.load  = load && (load_idx[IW-1:0] == IW'(g));
    tobm_cell u_cell (
      .clk(clk), .ctl(c),
      .prev(q[(g + 1) % BOOK_DEPTH]),
      .head_new(head_new),
      .use_head(g == BOOK_DEPTH - 1),
      .load_val(load_val),
      .q(q[g])
    );
  end
  assign head = q[0];
endmodule
`default_nettype wire

/* design/tick_order_book_matcher.sv */
// Top level: price/time priority matcher over two rings of book cells.
//
//   channel | dir | payload
//   req     | in  | func, side, price, volume, queue_ahead, order_id, timestamp
//   rsp     | out | has_fill, fill_side, fill_price, fill_volume, filled_id,
//           |     | fill_time, status, last
//
// One transaction at a time. A tick turns its side's ring fully twice, one
// slot per cycle unless the ring stalls: a pass for queue reset, then a pass
// for matching, each over all BOOK_DEPTH slots. Append, clear and other items
// answer with a single result without turning a ring.
// Reset (rst, synchronous) clears counts and control; slot contents are valid
// only below the count. The newest fill is held back so the final one can carry
// last; the ring stalls only when a further fill finds the output still busy.
`timescale 1ns / 1ps
`default_nettype none
module tick_order_book_matcher import tobm_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  tobm_req_if.sink   req,
  tobm_rsp_if.source rsp
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_QRST  = 5'b00010,
    S_MATCH = 5'b00100,
    S_EMPTY = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state;
  req_t   cur;
  logic [CNT_W-1:0] ask_count, bid_count, pos;
  logic        qstop;     // queue-reset walk hit a non-better entry
  logic        mstop;     // matching stopped
  logic [31:0] tv;        // remaining tick volume
  logic        reject;    // append refused, list full
  logic        pvalid;    // a fill waits in pdata
  rsp_t        pdata;     // newest fill of the running tick
  logic        ovalid;
  rsp_t        odata;

  logic   buy;
  logic   shift_a, shift_b, load_a, load_b;
  entry_t head_a, head_b, head, head_new;
  logic [CNT_W-1:0] n;

  assign buy  = (cur.side == SIDE_BUY);
  assign head = buy ? head_a : head_b;
  assign n    = buy ? ask_count : bid_count;

  // Head-slot evaluation for the current walk position.
  logic in_range, better, equal;
  logic [31:0] avail, fill;
  logic emit;
  assign in_range = (pos < n);
  assign better   = buy ? (cur.price > head.price) : (cur.price < head.price);
  assign equal    = (cur.price == head.price);
  assign avail    = tv - head.queue;

  always_comb begin
    head_new = head;
    fill = '0;
    emit = 1'b0;
    if (state == S_QRST) begin
      if (in_range && !qstop && better) head_new.queue = '0;
    end else if (state == S_MATCH && in_range && !mstop && head.volume != 0 &&
                 tv != 0 && (better || equal)) begin
      if (equal) begin
        if (head.queue >= tv) begin
          head_new.queue = head.queue - tv;
        end else begin
          fill = (avail >= head.volume) ? head.volume : avail;
          head_new.queue = '0;
          emit = 1'b1;
        end
      end else begin
        fill = (tv >= head.volume) ? head.volume : tv;
        emit = 1'b1;
      end
      head_new.volume = head.volume - fill;
    end
  end

  // A new fill pushes the held one out; it waits only if the output is busy.
  logic walking, step, out_free;
  assign out_free = !ovalid || rsp.ready;
  assign walking  = (state == S_QRST) || (state == S_MATCH);
  assign step     = walking && !(emit && pvalid && !out_free);
  assign shift_a  = step && buy;
  assign shift_b  = step && !buy;

  entry_t app;
  assign app.price  = req.data.price;
  assign app.volume = req.data.volume;
  assign app.queue  = req.data.queue_ahead;
  assign app.ident  = req.data.order_id;

  logic acc;
  assign req.ready = (state == S_IDLE) && !ovalid;
  assign acc = req.valid && req.ready;
  assign load_a = acc && req.data.func == FUNC_APPEND && req.data.side == SIDE_BUY &&
                  ask_count < CNT_W'(BOOK_DEPTH);
  assign load_b = acc && req.data.func == FUNC_APPEND && req.data.side == SIDE_SELL &&
                  bid_count < CNT_W'(BOOK_DEPTH);

  tobm_side u_ask (.clk(clk), .shift(shift_a), .load(load_a), .load_idx(ask_count),
                   .load_val(app), .head_new(head_new), .head(head_a));
  tobm_side u_bid (.clk(clk), .shift(shift_b), .load(load_b), .load_idx(bid_count),
                   .load_val(app), .head_new(head_new), .head(head_b));

  logic last_pos;
  assign last_pos = (pos == CNT_W'(BOOK_DEPTH - 1));

  rsp_t fill_word;
  always_comb begin
    fill_word = '0;
    fill_word.has_fill    = 1'b1;
    fill_word.fill_side   = buy;
    fill_word.fill_price  = head.price;
    fill_word.fill_volume = fill;
    fill_word.filled_id   = head.ident;
    fill_word.fill_time   = cur.timestamp;
  end

  // Output register loads: a displaced fill, the closing result, or a reply.
  logic load_out;
  rsp_t out_word;
  always_comb begin
    load_out = 1'b0;
    out_word = '0;
    if (state == S_MATCH && step && emit && pvalid) begin
      load_out = 1'b1;
      out_word = pdata;
    end else if (state == S_EMPTY && out_free) begin
      load_out = 1'b1;
      out_word = pvalid ? pdata : '0;
      out_word.last = 1'b1;
    end else if (state == S_OUT) begin
      load_out = 1'b1;
      out_word.status = reject;
      out_word.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (load_out) begin
      ovalid <= 1'b1;
    end else if (rsp.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) odata <= out_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ask_count <= '0;
      bid_count <= '0;
      pvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            cur <= req.data;
            pos <= '0;
            qstop <= 1'b0;
            mstop <= 1'b0;
            tv <= req.data.volume;
            pvalid <= 1'b0;
            reject <= req.data.func == FUNC_APPEND &&
                      ((req.data.side == SIDE_BUY && ask_count >= CNT_W'(BOOK_DEPTH)) ||
                       (req.data.side == SIDE_SELL && bid_count >= CNT_W'(BOOK_DEPTH)));
            if (req.data.func == FUNC_TICK &&
                (req.data.side == SIDE_BUY || req.data.side == SIDE_SELL)) begin
              state <= S_QRST;
            end else begin
              state <= S_OUT;
              if (req.data.func == FUNC_CLEAR) begin
                ask_count <= '0;
                bid_count <= '0;
              end
              if (load_a) ask_count <= ask_count + 1'b1;
              if (load_b) bid_count <= bid_count + 1'b1;
            end
          end
        end
        S_QRST: begin
          if (step) begin
            if (in_range && !better) qstop <= 1'b1;
            pos <= last_pos ? '0 : pos + 1'b1;
            if (last_pos) state <= S_MATCH;
          end
        end
        S_MATCH: begin
          if (step) begin
            if (in_range && !mstop && head.volume != 0 &&
                (tv == 0 || !(better || equal))) mstop <= 1'b1;
            if (emit) begin
              tv <= tv - fill;
              pvalid <= 1'b1;
              pdata <= fill_word;
            end
            pos <= pos + 1'b1;
            if (last_pos) state <= S_EMPTY;
          end
        end
        S_EMPTY: begin
          // Close out: the held fill leaves marked last, or one empty result.
          if (out_free) begin
            pvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid = ovalid;
  assign rsp.data  = odata;
endmodule
`default_nettype wire

/* design/tobm_checker.sv */
// Checker: port-level properties of the matcher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tobm_checker import tobm_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp_data
);
  a_nofill_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.has_fill |-> rsp_data.fill_volume == 0 &&
      rsp_data.filled_id == 0) else $error("empty result carries fill data");
  a_fill_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.has_fill |-> rsp_data.fill_volume != 0)
    else $error("zero-volume fill");
  a_fill_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.has_fill |-> !rsp_data.status)
    else $error("fill with reject status");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result changed");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second transaction accepted back to back");
endmodule

bind tick_order_book_matcher tobm_checker u_tobm_checker (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
`default_nettype wire

/* test/tb.sv */
// Testbench for the tick order book matcher: book model, stimulus and result checks.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import tobm_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tobm_req_if req_ch ();
  tobm_rsp_if rsp_ch ();

  tick_order_book_matcher i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Book model: both sides, BOOK_DEPTH entries each, in append order.
  logic [31:0] bk_price [2][BOOK_DEPTH];
  logic [31:0] bk_vol   [2][BOOK_DEPTH];
  logic [31:0] bk_queue [2][BOOK_DEPTH];
  logic [15:0] bk_ident [2][BOOK_DEPTH];
  int unsigned bk_count [2];

  rsp_t fills_due [$];   // expected results, oldest first
  int   mismatches = 0;
  longint cycles = 0;

  // Sink and source pacing.
  bit  sink_calm = 1'b0;   // no idling at all
  bit  sink_hold = 1'b0;   // long hold-off
  bit  src_calm = 1'b0;

  // Better for the tick: lower ask for a buy, higher bid for a sell.
  function automatic bit price_beats(logic [31:0] tp, logic [31:0] op, bit buy);
    return buy ? (tp > op) : (tp < op);
  endfunction

  function automatic rsp_t no_fill(bit st);
    rsp_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  // Works out the results of one request and updates the book model.
  task automatic predict_book(req_t q);
    rsp_t        r;
    int          s;
    int unsigned n;
    int          nf;
    bit          buy;
    logic [31:0] tv;
    logic [31:0] fill;
    logic [31:0] avail;
    bit          st;
    nf = 0;
    st = 1'b0;
    if (q.func == FUNC_TICK && q.side inside {SIDE_BUY, SIDE_SELL}) begin
      buy = (q.side == SIDE_BUY);
      s = buy ? 0 : 1;   // buy walks asks
      n = bk_count[s];
      tv = q.volume;
      for (int i = 0; i < n; i++) begin
        if (!price_beats(q.price, bk_price[s][i], buy)) break;
        bk_queue[s][i] = '0;
      end
      for (int i = 0; i < n && nf < 16; i++) begin
        if (bk_vol[s][i] == 0) continue;
        if (tv == 0 || (q.price != bk_price[s][i] && !price_beats(q.price, bk_price[s][i], buy)))
          break;
        if (q.price == bk_price[s][i]) begin
          // equal price: queue ahead trades first
          if (bk_queue[s][i] >= tv) begin
            bk_queue[s][i] -= tv;
            continue;
          end
          avail = tv - bk_queue[s][i];
          fill = (avail >= bk_vol[s][i]) ? bk_vol[s][i] : avail;
          bk_queue[s][i] = '0;
        end else begin
          fill = (tv >= bk_vol[s][i]) ? bk_vol[s][i] : tv;
        end
        tv -= fill;
        bk_vol[s][i] -= fill;
        r = '0;
        r.has_fill = 1'b1;
        r.fill_side = buy;
        r.fill_price = bk_price[s][i];
        r.fill_volume = fill;
        r.filled_id = bk_ident[s][i];
        r.fill_time = q.timestamp;
        fills_due = {fills_due, r};
        nf++;
      end
    end else if (q.func == FUNC_APPEND && q.side inside {2'd0, 2'd1}) begin
      s = q.side[0];
      if (bk_count[s] >= BOOK_DEPTH) begin
        st = 1'b1;
      end else begin
        bk_price[s][bk_count[s]] = q.price;
        bk_vol[s][bk_count[s]] = q.volume;
        bk_queue[s][bk_count[s]] = q.queue_ahead;
        bk_ident[s][bk_count[s]] = q.order_id;
        bk_count[s]++;
      end
    end else if (q.func == FUNC_CLEAR) begin
      bk_count[0] = 0;
      bk_count[1] = 0;
    end
    if (nf == 0) fills_due = {fills_due, no_fill(st)};
    fills_due[fills_due.size() - 1].last = 1'b1;
  endtask

  // Sends one transaction; the prediction is made at acceptance.
  task automatic send_req(req_t q);
    req_ch.valid <= 1'b1;
    req_ch.data <= q;
    forever begin
      @(posedge clk);
      if (req_ch.ready) break;
    end
    predict_book(q);
    if (!src_calm && $urandom_range(99) < 24) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic finish_tx();
    req_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic req_t mk(logic [1:0] f, logic [1:0] sd, logic [31:0] p,
                              logic [31:0] v, logic [31:0] qa, logic [15:0] id,
                              logic [47:0] ts);
    req_t q;
    q.func = f; q.side = sd; q.price = p; q.volume = v;
    q.queue_ahead = qa; q.order_id = id; q.timestamp = ts;
    return q;
  endfunction

  function automatic logic [47:0] rnd_ts();
    return {16'($urandom_range(16'hffff)), $urandom()};
  endfunction

  // Result checker: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    cycles <= cycles + 1;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (fills_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = fills_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // Receiver pacing: random idling, calm stretches and a long hold-off.
  always @(posedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else if (sink_hold) rsp_ch.ready <= 1'b0;
    else if (sink_calm) rsp_ch.ready <= 1'b1;
    else rsp_ch.ready <= ($urandom_range(99) >= 24);
  end

  initial begin
    int hold_cnt;
    wait (sink_hold);
    hold_cnt = 0;
    while (hold_cnt < 300) begin
      @(posedge clk);
      hold_cnt++;
    end
    sink_hold = 1'b0;
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("tick_order_book_matcher: mismatch");
      $finish;
    end
  end

  // Directed: edges of fields, every function, each special case.
  task automatic test_directed();
    send_req(mk(FUNC_TICK, SIDE_BUY, 32'd100, 32'd5, 0, 0, 48'h1));     // empty book
    send_req(mk(FUNC_APPEND, 2'd0, 32'd10, 32'd3, 32'd0, 16'hffff, 0));
    send_req(mk(FUNC_APPEND, 2'd0, 32'd20, 32'd4, 32'd7, 16'h0001, 0));
    send_req(mk(FUNC_APPEND, 2'd0, 32'd30, 32'hffffffff, 32'hffffffff, 16'h0, 0));
    send_req(mk(FUNC_APPEND, 2'd2, 32'd1, 32'd1, 32'd1, 16'h5, 0));     // ignored side
    send_req(mk(FUNC_APPEND, 2'd3, 32'd1, 32'd1, 32'd1, 16'h5, 0));
    send_req(mk(FUNC_TICK, SIDE_BUY, 32'd20, 32'd5, 0, 0, 48'hffffffffffff)); // queue eats
    send_req(mk(FUNC_TICK, SIDE_BUY, 32'd20, 32'd9, 0, 0, 48'h2));
    send_req(mk(FUNC_TICK, SIDE_BUY, 32'd30, 32'd0, 0, 0, 48'h3));      // zero volume
    send_req(mk(FUNC_TICK, 2'd2, 32'd30, 32'd9, 0, 0, 48'h4));
    send_req(mk(FUNC_TICK, 2'd3, 32'd30, 32'd9, 0, 0, 48'h4));
    send_req(mk(FUNC_TICK, SIDE_BUY, 32'hffffffff, 32'hffffffff, 0, 0, 48'h5));
    send_req(mk(FUNC_APPEND, 2'd1, 32'hffffffff, 32'd8, 32'd2, 16'h1234, 0));
    send_req(mk(FUNC_APPEND, 2'd1, 32'd0, 32'd8, 32'd0, 16'h4321, 0));
    send_req(mk(FUNC_TICK, SIDE_SELL, 32'd0, 32'd20, 0, 0, 48'h6));
    send_req(mk(2'd3, 2'd0, 32'd1, 32'd1, 32'd1, 16'h1, 48'h1));         // unused func
    for (int i = 0; i < 17; i++)                                         // fill, then reject
      send_req(mk(FUNC_APPEND, 2'd1, 32'd50, 32'd1, 32'd0, 16'(i), 0));
    send_req(mk(FUNC_TICK, SIDE_SELL, 32'd1, 32'd100, 0, 0, 48'h7));     // fourteen fills
    send_req(mk(FUNC_CLEAR, 2'd0, 0, 0, 0, 0, 0));
    finish_tx();
  endtask

  // Random: mostly small books with prices near each other, then ticks.
  task automatic test_random(int items);
    int   sent;
    req_t q;
    logic [31:0] base;
    sent = 0;
    while (sent < items) begin
      base = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(100, 90);
      if ($urandom_range(9) < 2) begin
        q = mk(FUNC_CLEAR, 2'($urandom_range(3)), $urandom(), $urandom(), $urandom(),
               16'($urandom()), rnd_ts());
        send_req(q);
        sent++;
      end
      repeat ($urandom_range(8)) begin
        q = mk(FUNC_APPEND, ($urandom_range(19) == 0) ? 2'($urandom_range(3)) :
               2'($urandom_range(1)), base + $urandom_range(6) - 3,
               ($urandom_range(9) == 0) ? $urandom() : $urandom_range(20),
               ($urandom_range(9) == 0) ? $urandom() : $urandom_range(10),
               16'($urandom()), rnd_ts());
        send_req(q);
        sent++;
      end
      repeat ($urandom_range(4, 1)) begin
        q = mk(($urandom_range(19) == 0) ? 2'd3 : FUNC_TICK,
               ($urandom_range(14) == 0) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1)),
               base + $urandom_range(8) - 4,
               ($urandom_range(9) == 0) ? $urandom() : $urandom_range(40),
               $urandom(), 16'($urandom()), rnd_ts());
        send_req(q);
        sent++;
      end
    end
    finish_tx();
  endtask

  // Receiver holds off while the sender keeps offering, to stall the input.
  task automatic test_backpressure();
    sink_hold = 1'b1;
    for (int i = 0; i < 8; i++)
      send_req(mk(FUNC_APPEND, 2'($urandom_range(1)), 32'd60, 32'd2, 0, 16'(i), 0));
    send_req(mk(FUNC_TICK, SIDE_BUY, 32'd61, 32'd50, 0, 0, rnd_ts()));
    send_req(mk(FUNC_TICK, SIDE_SELL, 32'd59, 32'd50, 0, 0, rnd_ts()));
    finish_tx();
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    bk_count[0] = 0;
    bk_count[1] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(100);
    test_backpressure();
    sink_calm = 1'b1;   // stretch with no idling on either side
    src_calm = 1'b1;
    test_random(60);
    sink_calm = 1'b0;
    src_calm = 1'b0;
    test_random(100);
    while (fills_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("tick_order_book_matcher: match");
    end else begin
      $display("tick_order_book_matcher: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
design/tobm_pkg.sv
design/tobm_if.sv
design/tobm_cell.sv
design/tobm_side.sv
design/tick_order_book_matcher.sv
design/tobm_checker.sv
test/tb.sv
